[design/ort_pkg.sv]
// shared types and constants for the outstanding request tracker
`default_nettype none
package ort_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned TimeoutW = 31;
  localparam int unsigned OffsetW = 16;
  localparam int unsigned CountOutW = 5;
  localparam logic [TimeoutW-1:0] TimeoutReset = TimeoutW'(1000);

  typedef enum logic [1:0] {
    OP_INSERT    = 2'd0,
    OP_MATCH_RSP = 2'd1,
    OP_MATCH_REQ = 2'd2,
    OP_PURGE     = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_EVICTED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_PURGED    = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TIMEOUT_TICKS = CfgIdxW'(0),
    REG_AGE_OFFSET    = CfgIdxW'(1)
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  netfn;
    logic [7:0]  cmd;
    logic [5:0]  tgt_seq;
    logic [5:0]  src_seq;
    logic [7:0]  src_interface;
    logic [7:0]  dst_interface;
    logic [31:0] time_now;
  } req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [5:0]           seq_out;
    logic [7:0]           src_interface_out;
    logic [7:0]           dst_interface_out;
    logic [CountOutW-1:0] removed_count;
    logic [CountOutW-1:0] occupancy;
  } rsp_t;

  typedef struct packed {
    logic [5:0]  netfn;
    logic [7:0]  cmd;
    logic [5:0]  tgt_seq;
    logic [5:0]  src_seq;
    logic [7:0]  src_interface;
    logic [7:0]  dst_interface;
    logic [31:0] stamp;
  } entry_t;

endpackage
`default_nettype wire

[design/outstanding_request_tracker_top.sv]
// outstanding request table: ordered entry store, sequencer and result register
//
// Keeps up to 16 sent requests in arrival order. Each beat is one operation:
// insert (evicting the oldest entry when full), match a response, match a
// request, or purge expired entries. Every operation walks the stored entries
// once through a single read port and compacts the table in place through a
// single write port, and the input stalls until the result has been registered.
// The result sits in an output register, so a stalled result only holds the
// block once the next operation has finished.
// Configuration writes are always taken and must arrive while the block idles.
`default_nettype none
module outstanding_request_tracker_top
  import ort_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire req_t                in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output rsp_t                     out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e              state_q;
  req_t                req_q;
  logic [31:0]         base_q;
  logic [CntW-1:0]     cnt_q;
  logic [CntW-1:0]     rd_q;
  logic [CntW-1:0]     rd_d;
  logic [CntW-1:0]     wr_q;
  logic [CntW-1:0]     removed_q;
  logic                found_q;
  logic                evict_q;
  logic [5:0]          seq_hit_q;
  logic [7:0]          src_hit_q;
  logic [7:0]          dst_hit_q;
  logic                out_valid_q;
  rsp_t                out_q;
  logic [TimeoutW-1:0] timeout_q;
  logic [OffsetW-1:0]  offset_q;

  entry_t mem_q [Depth];
  entry_t ent_q;

  entry_t          new_ent;
  logic            scan_end;
  logic            rsp_hit;
  logic            req_hit;
  logic [31:0]     age;
  logic            expired;
  logic            drop;
  logic            mem_we;
  logic [IdxW-1:0] mem_wa;
  entry_t          mem_wd;
  logic            in_fire;
  logic            out_load;
  logic [2:0]      status_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    scan_end = (rd_q == cnt_q);
    rsp_hit  = (req_q.netfn != 6'd0) && (ent_q.netfn == req_q.netfn - 6'd1) &&
               (ent_q.cmd == req_q.cmd) && (ent_q.tgt_seq == req_q.tgt_seq);
    req_hit  = (ent_q.netfn == req_q.netfn) && (ent_q.cmd == req_q.cmd) &&
               (ent_q.src_seq == req_q.src_seq);
    age      = base_q - ent_q.stamp;
    expired  = (age > {1'b0, timeout_q});
    case (req_q.opcode)
      OP_INSERT:    drop = evict_q && (rd_q == '0);
      OP_MATCH_RSP: drop = !found_q && rsp_hit;
      OP_MATCH_REQ: drop = !found_q && req_hit;
      OP_PURGE:     drop = expired;
      default:      drop = 1'b0;
    endcase
  end

  // read address runs one entry ahead of the registered read data
  always_comb begin
    rd_d = rd_q;
    if (in_fire) begin
      rd_d = '0;
    end else if ((state_q == S_SCAN) && !scan_end) begin
      rd_d = rd_q + CntW'(1);
    end
  end

  always_comb begin
    new_ent.netfn         = req_q.netfn;
    new_ent.cmd           = req_q.cmd;
    new_ent.tgt_seq       = req_q.tgt_seq;
    new_ent.src_seq       = req_q.src_seq;
    new_ent.src_interface = req_q.src_interface;
    new_ent.dst_interface = req_q.dst_interface;
    new_ent.stamp         = req_q.time_now;
    mem_we = 1'b0;
    mem_wa = wr_q[IdxW-1:0];
    mem_wd = ent_q;
    if (state_q == S_SCAN) begin
      if (scan_end) begin
        mem_we = (req_q.opcode == OP_INSERT);
        mem_wd = new_ent;
      end else begin
        mem_we = !drop && (wr_q != rd_q);
      end
    end
  end

  always_comb begin
    case (req_q.opcode)
      OP_INSERT:    status_d = evict_q ? ST_EVICTED : ST_INSERTED;
      OP_MATCH_RSP,
      OP_MATCH_REQ: status_d = found_q ? ST_FOUND : ST_NOT_FOUND;
      OP_PURGE:     status_d = ST_PURGED;
      default:      status_d = ST_NOT_FOUND;
    endcase
  end

  // entry store, one read and one write a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    ent_q <= mem_q[rd_d[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      base_q      <= '0;
      cnt_q       <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      removed_q   <= '0;
      found_q     <= 1'b0;
      evict_q     <= 1'b0;
      seq_hit_q   <= '0;
      src_hit_q   <= '0;
      dst_hit_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      timeout_q   <= TimeoutReset;
      offset_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_TIMEOUT_TICKS: timeout_q <= cfg_data_i[TimeoutW-1:0];
          REG_AGE_OFFSET:    offset_q  <= cfg_data_i[OffsetW-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      rd_q <= rd_d;
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            req_q     <= in_data_i;
            base_q    <= in_data_i.time_now + {16'd0, offset_q};
            wr_q      <= '0;
            removed_q <= '0;
            found_q   <= 1'b0;
            evict_q   <= (in_data_i.opcode == OP_INSERT) && (cnt_q == CntW'(Depth));
            seq_hit_q <= '0;
            src_hit_q <= '0;
            dst_hit_q <= '0;
            state_q   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            cnt_q   <= (req_q.opcode == OP_INSERT) ? wr_q + CntW'(1) : wr_q;
            state_q <= S_DONE;
          end else begin
            if (drop) begin
              removed_q <= removed_q + CntW'(1);
              if (req_q.opcode == OP_MATCH_RSP || req_q.opcode == OP_MATCH_REQ) begin
                found_q   <= 1'b1;
                seq_hit_q <= (req_q.opcode == OP_MATCH_RSP) ? ent_q.src_seq
                                                            : ent_q.tgt_seq;
                src_hit_q <= ent_q.src_interface;
                dst_hit_q <= ent_q.dst_interface;
              end
            end else begin
              wr_q <= wr_q + CntW'(1);
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_q.status            <= status_d;
            out_q.seq_out           <= seq_hit_q;
            out_q.src_interface_out <= src_hit_q;
            out_q.dst_interface_out <= dst_hit_q;
            out_q.removed_count     <= CountOutW'(removed_q);
            out_q.occupancy         <= CountOutW'(cnt_q);
            state_q                 <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("entry count beyond table depth");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (wr_q <= rd_q) && (rd_q <= cnt_q))
    else $error("scan pointers out of order");

  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_SCAN) && (rd_q == '0))
    else $error("accepted beat did not start a scan");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && (state_q == S_IDLE))
    else $error("finished result not registered");

endmodule
`default_nettype wire

[tb/ort_table_checker.sv]
// checker for the outstanding request tracker: table predictor and result comparison
module ort_table_checker
  import ort_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  req_t                in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  rsp_t                out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         pending_o,
  output int unsigned         errors_o
);

  entry_t              table_slots [Depth];
  int                  held;
  logic [TimeoutW-1:0] timeout_ticks;
  logic [OffsetW-1:0]  age_offset;
  rsp_t                expected_q [$];
  int unsigned         fail_tally = 0;

  function automatic void drop_slot(input int pos);
    for (int j = pos; j < held - 1; j++) begin
      table_slots[j] = table_slots[j + 1];
    end
    held--;
  endfunction

  function automatic rsp_t track_beat(input req_t b);
    rsp_t        r;
    logic [31:0] base;
    logic [31:0] age;
    int          i;
    bit          hit;
    r = '0;
    case (opcode_e'(b.opcode))
      OP_INSERT: begin
        r.status = ST_INSERTED;
        if (held >= Depth) begin
          drop_slot(0);
          r.status = ST_EVICTED;
          r.removed_count = CountOutW'(1);
        end
        table_slots[held] = '{netfn: b.netfn, cmd: b.cmd, tgt_seq: b.tgt_seq,
                              src_seq: b.src_seq, src_interface: b.src_interface,
                              dst_interface: b.dst_interface, stamp: b.time_now};
        held++;
      end
      OP_MATCH_RSP, OP_MATCH_REQ: begin
        r.status = ST_NOT_FOUND;
        for (i = 0; i < held; i++) begin
          if (opcode_e'(b.opcode) == OP_MATCH_RSP) begin
            hit = b.netfn != 6'd0 && table_slots[i].netfn == b.netfn - 6'd1 &&
                  table_slots[i].cmd == b.cmd && table_slots[i].tgt_seq == b.tgt_seq;
          end else begin
            hit = table_slots[i].netfn == b.netfn && table_slots[i].cmd == b.cmd &&
                  table_slots[i].src_seq == b.src_seq;
          end
          if (hit) begin
            r.seq_out = (opcode_e'(b.opcode) == OP_MATCH_RSP) ? table_slots[i].src_seq
                                                              : table_slots[i].tgt_seq;
            r.src_interface_out = table_slots[i].src_interface;
            r.dst_interface_out = table_slots[i].dst_interface;
            r.status = ST_FOUND;
            r.removed_count = CountOutW'(1);
            drop_slot(i);
            break;
          end
        end
      end
      default: begin
        r.status = ST_PURGED;
        base = b.time_now + {16'd0, age_offset};
        i = 0;
        while (i < held) begin
          age = base - table_slots[i].stamp;
          if (age > {1'b0, timeout_ticks} || age[31]) begin
            drop_slot(i);
            r.removed_count = r.removed_count + CountOutW'(1);
          end else begin
            i++;
          end
        end
      end
    endcase
    r.occupancy = CountOutW'(held);
    return r;
  endfunction

  function automatic int unsigned check_field(input string name, input logic [31:0] want,
                                              input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      held = 0;
      timeout_ticks = TimeoutReset;
      age_offset = '0;
      expected_q.delete();
      pending_o <= 0;
      errors_o <= fail_tally;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_TIMEOUT_TICKS: timeout_ticks = cfg_data_i[TimeoutW-1:0];
          REG_AGE_OFFSET:    age_offset = cfg_data_i[OffsetW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no expectation: status %0d", out_data_i.status);
          fail_tally++;
        end else begin
          want = expected_q.pop_front();
          fail_tally += check_field("status", 32'(want.status), 32'(out_data_i.status));
          fail_tally += check_field("seq_out", 32'(want.seq_out), 32'(out_data_i.seq_out));
          fail_tally += check_field("src_interface_out", 32'(want.src_interface_out),
                                    32'(out_data_i.src_interface_out));
          fail_tally += check_field("dst_interface_out", 32'(want.dst_interface_out),
                                    32'(out_data_i.dst_interface_out));
          fail_tally += check_field("removed_count", 32'(want.removed_count),
                                    32'(out_data_i.removed_count));
          fail_tally += check_field("occupancy", 32'(want.occupancy),
                                    32'(out_data_i.occupancy));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(track_beat(in_data_i));
      end
      pending_o <= expected_q.size();
      errors_o <= fail_tally;
    end
  end

endmodule

[tb/outstanding_request_tracker_top_tb.sv]
// testbench top for the outstanding request tracker: clock, reset, stimulus and verdict
module outstanding_request_tracker_top_tb;
  import ort_pkg::*;

  localparam int          PhaseItems = 400;
  localparam int          Phases     = 5;
  localparam int          LongHold   = 300;
  localparam int unsigned CycleLimit = 400000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  req_t                in_beat = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rsp_t                out_beat;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  int unsigned         pending;
  int unsigned         errors;
  int unsigned         cycles = 0;

  bit          tx_jitter = 1'b1;
  bit          rx_jitter = 1'b1;
  bit          want_long_hold = 1'b0;
  req_t        recent_inserts [$];
  logic [31:0] ticks;

  always #2 clk = ~clk;

  outstanding_request_tracker_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  ort_table_checker u_table_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_beat),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (want_long_hold) begin
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        want_long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (rx_jitter && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic req_t make_beat(input opcode_e op, input logic [5:0] netfn,
                                     input logic [7:0] cmd, input logic [5:0] seq_t,
                                     input logic [5:0] seq_s, input logic [7:0] src,
                                     input logic [7:0] dst, input logic [31:0] now);
    return '{opcode: op, netfn: netfn, cmd: cmd, tgt_seq: seq_t, src_seq: seq_s,
             src_interface: src, dst_interface: dst, time_now: now};
  endfunction

  task automatic send_beat(input req_t b);
    if (tx_jitter && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly well-formed traffic: inserts, then matches built from earlier inserts
  function automatic req_t random_beat;
    req_t        b;
    req_t        pick;
    int unsigned roll;
    int unsigned k;
    roll = $urandom_range(0, 99);
    b.opcode = OP_INSERT;
    b.netfn = $urandom_range(0, 1) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, 63));
    b.cmd = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    b.tgt_seq = 6'($urandom_range(0, 63));
    b.src_seq = 6'($urandom_range(0, 63));
    b.src_interface = 8'($urandom_range(0, 255));
    b.dst_interface = 8'($urandom_range(0, 255));
    b.time_now = ticks;
    ticks = ticks + $urandom_range(0, 400);
    if (roll < 40) begin
      recent_inserts.push_back(b);
      if (recent_inserts.size() > 24) void'(recent_inserts.pop_front());
    end else if (roll < 75 && recent_inserts.size() > 0) begin
      k = $urandom_range(0, recent_inserts.size() - 1);
      pick = recent_inserts[k];
      recent_inserts.delete(k);
      b.cmd = pick.cmd;
      if (roll < 58) begin
        b.opcode = OP_MATCH_RSP;
        b.netfn = pick.netfn + 6'd1;
        b.tgt_seq = pick.tgt_seq;
      end else begin
        b.opcode = OP_MATCH_REQ;
        b.netfn = pick.netfn;
        b.src_seq = pick.src_seq;
      end
    end else if (roll < 85) begin
      b.opcode = OP_PURGE;
    end else if (roll < 95) begin
      b.opcode = $urandom_range(0, 1) ? OP_MATCH_RSP : OP_MATCH_REQ;
    end else begin
      b.opcode = opcode_e'($urandom_range(0, 3));
      b.time_now = $urandom;
    end
    return b;
  endfunction

  initial begin
    ticks = $urandom;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, netfn zero response, eviction, purge
    send_beat(make_beat(OP_MATCH_RSP, 6'd1, 8'd0, 6'd0, 6'd0, 8'd0, 8'd0, 32'd0));
    send_beat(make_beat(OP_PURGE, 6'd0, 8'd0, 6'd0, 6'd0, 8'd0, 8'd0, 32'd0));
    send_beat(make_beat(OP_INSERT, 6'd0, 8'd0, 6'd0, 6'd0, 8'd0, 8'd0, 32'd0));
    send_beat(make_beat(OP_INSERT, 6'd63, 8'd255, 6'd63, 6'd63, 8'd255, 8'd255,
                        32'hFFFF_FFFF));
    send_beat(make_beat(OP_MATCH_RSP, 6'd0, 8'd255, 6'd63, 6'd63, 8'd0, 8'd0, 32'd0));
    send_beat(make_beat(OP_MATCH_RSP, 6'd1, 8'd0, 6'd0, 6'd0, 8'd0, 8'd0, 32'd0));
    send_beat(make_beat(OP_MATCH_REQ, 6'd63, 8'd255, 6'd0, 6'd63, 8'd0, 8'd0, 32'd0));
    for (int i = 1; i <= Depth + 1; i++) begin
      send_beat(make_beat(OP_INSERT, 6'(i % 4), 8'h20, 6'(i), 6'(63 - i), 8'(i),
                          8'(255 - i), 32'(i * 100)));
    end
    send_beat(make_beat(OP_PURGE, 6'd0, 8'd0, 6'd0, 6'd0, 8'd0, 8'd0, 32'd1650));
    drain();

    for (int phase = 0; phase < Phases; phase++) begin
      case (phase)
        1: begin
          write_reg(REG_TIMEOUT_TICKS, {1'($urandom), 31'd0});
          write_reg(REG_AGE_OFFSET, {16'($urandom), 16'hFFFF});
        end
        2: begin
          write_reg(REG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
          write_reg(REG_AGE_OFFSET, {16'($urandom), 16'd0});
          write_reg(CfgIdxW'($urandom_range(int'(REG_AGE_OFFSET) + 1, (1 << CfgIdxW) - 1)),
                    $urandom);
        end
        3: begin
          write_reg(REG_TIMEOUT_TICKS, 32'($urandom_range(0, 3000)));
          write_reg(REG_AGE_OFFSET, $urandom);
        end
        4: begin
          write_reg(REG_TIMEOUT_TICKS, 32'd1000);
          write_reg(REG_AGE_OFFSET, 32'($urandom_range(0, 2000)));
        end
        default: ;
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == 2 && n == 100) want_long_hold = 1'b1;
        if (phase == Phases - 1 && n == PhaseItems - 250) begin
          tx_jitter = 1'b0;
          rx_jitter = 1'b0;
        end
        send_beat(random_beat());
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
